/* hdl/sdat_pkg.sv */
// shared types, constants and codes for the sorted device address table
package sdat_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = 48;
    localparam int KEY_W = ADDR_W + 1;
    localparam int TYPE_W = 8;
    localparam int INDEX_W = 8;
    localparam int OUT_COUNT_W = 5;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    // operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_GET    = 2'd3;

    // read address selection
    localparam logic [1:0] RD_PTR      = 2'd0;
    localparam logic [1:0] RD_PTR_PREV = 2'd1;
    localparam logic [1:0] RD_INDEX    = 2'd2;

    localparam logic [7:0] RANDOM_TOP_MASK = 8'hc0;

    typedef struct packed {
        logic       load_in;
        logic       ptr_clr;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       ptr_load_count;
        logic       pos_set;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_key;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       res_set;
        logic       res_ok;
        logic       res_get;
        logic       out_load;
    } sdat_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       stable;
        logic       ptr_lt_cnt;
        logic       ptr_gt_pos;
        logic       key_eq;
        logic       key_lt;
        logic       full;
        logic       idx_lt_cnt;
    } sdat_status_t;

endpackage

/* hdl/sdat_datapath.sv */
// table memory, key and pointer registers, compare logic and result registers
module sdat_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sdat_pkg::sdat_cmd_t               cmd,
    output sdat_pkg::sdat_status_t            status,
    input  logic [1:0]                        in_op,
    input  logic [sdat_pkg::TYPE_W-1:0]       in_addr_type,
    input  logic [sdat_pkg::ADDR_W-1:0]       in_device_address,
    input  logic [sdat_pkg::INDEX_W-1:0]      in_entry_index,
    output logic                              out_ok,
    output logic                              out_type,
    output logic [sdat_pkg::ADDR_W-1:0]       out_address,
    output logic [sdat_pkg::OUT_COUNT_W-1:0]  out_count
);

    logic [sdat_pkg::KEY_W-1:0]       table_mem [sdat_pkg::CAPACITY];
    logic [sdat_pkg::KEY_W-1:0]       rd_data_reg;
    logic [sdat_pkg::KEY_W-1:0]       key_reg;
    logic [1:0]                       op_reg;
    logic                             stable_reg;
    logic [sdat_pkg::INDEX_W-1:0]     idx_reg;
    logic [sdat_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [sdat_pkg::CNT_W-1:0]       ptr_reg;
    logic [sdat_pkg::CNT_W-1:0]       pos_reg;
    logic                             res_ok_reg;
    logic                             res_get_reg;
    logic                             out_ok_reg;
    logic                             out_type_reg;
    logic [sdat_pkg::ADDR_W-1:0]      out_address_reg;
    logic [sdat_pkg::OUT_COUNT_W-1:0] out_count_reg;

    logic                             in_stable;
    logic [sdat_pkg::ADDR_W-3:0]      addr_rest;
    logic [sdat_pkg::IDX_W-1:0]       rd_addr;
    logic [sdat_pkg::IDX_W-1:0]       wr_addr;
    logic [sdat_pkg::KEY_W-1:0]       wr_data;

    // stable address check on the incoming item
    always_comb begin
        addr_rest = in_device_address[sdat_pkg::ADDR_W-3:0];
        in_stable = 1'b0;
        if (in_addr_type == sdat_pkg::TYPE_W'(0)) begin
            in_stable = (in_device_address != '0) && (in_device_address != '1);
        end else if (in_addr_type == sdat_pkg::TYPE_W'(1)) begin
            in_stable = (in_device_address != '0) && (in_device_address != '1)
                && ((in_device_address[sdat_pkg::ADDR_W-1 -: 8]
                     & sdat_pkg::RANDOM_TOP_MASK) == sdat_pkg::RANDOM_TOP_MASK)
                && (addr_rest != '0) && (addr_rest != '1);
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            sdat_pkg::RD_PTR:      rd_addr = ptr_reg[sdat_pkg::IDX_W-1:0];
            sdat_pkg::RD_PTR_PREV: rd_addr = sdat_pkg::IDX_W'(ptr_reg - sdat_pkg::CNT_W'(1));
            sdat_pkg::RD_INDEX:    rd_addr = idx_reg[sdat_pkg::IDX_W-1:0];
            default:               rd_addr = ptr_reg[sdat_pkg::IDX_W-1:0];
        endcase
        wr_addr = ptr_reg[sdat_pkg::IDX_W-1:0];
        wr_data = cmd.wr_key ? key_reg : rd_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + sdat_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= in_op;
            key_reg    <= {in_addr_type[0], in_device_address};
            stable_reg <= in_stable;
            idx_reg    <= in_entry_index;
        end
        if (cmd.ptr_clr) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_load_count) begin
            ptr_reg <= cnt_reg;
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + sdat_pkg::CNT_W'(1);
        end else if (cmd.ptr_dec) begin
            ptr_reg <= ptr_reg - sdat_pkg::CNT_W'(1);
        end
        if (cmd.pos_set) begin
            pos_reg <= ptr_reg;
        end
        if (cmd.res_set) begin
            res_ok_reg  <= cmd.res_ok;
            res_get_reg <= cmd.res_get;
        end
        if (cmd.out_load) begin
            out_ok_reg      <= res_ok_reg;
            out_type_reg    <= res_get_reg ? rd_data_reg[sdat_pkg::KEY_W-1] : 1'b0;
            out_address_reg <= res_get_reg ? rd_data_reg[sdat_pkg::ADDR_W-1:0] : '0;
            out_count_reg   <= sdat_pkg::OUT_COUNT_W'(cnt_reg);
        end
    end

    always_comb begin
        status.op         = op_reg;
        status.stable     = stable_reg;
        status.ptr_lt_cnt = ptr_reg < cnt_reg;
        status.ptr_gt_pos = ptr_reg > pos_reg;
        status.key_eq     = key_reg == rd_data_reg;
        status.key_lt     = key_reg < rd_data_reg;
        status.full       = cnt_reg == sdat_pkg::CAP_COUNT;
        status.idx_lt_cnt = idx_reg < sdat_pkg::INDEX_W'(cnt_reg);
    end

    assign out_ok      = out_ok_reg;
    assign out_type    = out_type_reg;
    assign out_address = out_address_reg;
    assign out_count   = out_count_reg;

endmodule

/* hdl/sdat_ctrl.sv */
// controller state machine: scan, shift and result sequencing
module sdat_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  sdat_pkg::sdat_status_t status,
    output sdat_pkg::sdat_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_READ     = 4'd2;
    localparam logic [3:0] ST_CMP      = 4'd3;
    localparam logic [3:0] ST_INS      = 4'd4;
    localparam logic [3:0] ST_SHIFT_RD = 4'd5;
    localparam logic [3:0] ST_SHIFT_WR = 4'd6;
    localparam logic [3:0] ST_GET_WAIT = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == ST_IDLE;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.rd_sel   = sdat_pkg::RD_PTR;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.op)
                    sdat_pkg::OP_LOOKUP, sdat_pkg::OP_INSERT: begin
                        if (status.stable) begin
                            state_next = ST_READ;
                        end else begin
                            cmd.res_set = 1'b1;
                            state_next  = ST_DONE;
                        end
                    end
                    sdat_pkg::OP_CLEAR: begin
                        cmd.cnt_clr = 1'b1;
                        cmd.res_set = 1'b1;
                        cmd.res_ok  = 1'b1;
                        state_next  = ST_DONE;
                    end
                    default: begin
                        if (status.idx_lt_cnt) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sdat_pkg::RD_INDEX;
                            state_next = ST_GET_WAIT;
                        end else begin
                            cmd.res_set = 1'b1;
                            state_next  = ST_DONE;
                        end
                    end
                endcase
            end
            ST_READ: begin
                if (status.ptr_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CMP;
                end else if (status.op == sdat_pkg::OP_INSERT) begin
                    // key sorts after every entry
                    cmd.pos_set = 1'b1;
                    state_next  = ST_INS;
                end else begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_CMP: begin
                if (status.key_eq) begin
                    cmd.res_set = 1'b1;
                    cmd.res_ok  = 1'b1;
                    state_next  = ST_DONE;
                end else if (status.key_lt) begin
                    // sorted table: no later entry can match
                    if (status.op == sdat_pkg::OP_INSERT) begin
                        cmd.pos_set = 1'b1;
                        state_next  = ST_INS;
                    end else begin
                        cmd.res_set = 1'b1;
                        state_next  = ST_DONE;
                    end
                end else begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_INS: begin
                if (status.full) begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    cmd.ptr_load_count = 1'b1;
                    state_next         = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (status.ptr_gt_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sdat_pkg::RD_PTR_PREV;
                    state_next = ST_SHIFT_WR;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.res_set = 1'b1;
                    cmd.res_ok  = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_SHIFT_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.ptr_dec = 1'b1;
                state_next  = ST_SHIFT_RD;
            end
            ST_GET_WAIT: begin
                cmd.res_set = 1'b1;
                cmd.res_ok  = 1'b1;
                cmd.res_get = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* hdl/sorted_device_address_table.sv */
// top level of the sorted device address table
// a sorted table of up to 16 device records {type, 48-bit address}, kept
// in ascending key order with the type as the most significant bit.
// input channel s_*: one item carries an op (lookup, insert, clear, get),
// an address type, an address and an entry index.
// result channel m_*: one item per input item with ok, the type and
// address read by get, and the entry count after the op.
// clear and rejected ops go straight to the result register; get reads
// the one entry at its index; lookup scans the entries in order, and
// insert also shifts the later entries up one at a time. the table memory,
// one read or one write per cycle, sets the scan and shift pace.
// one item is worked on at a time; s_ready is high only while the
// controller is idle, and a finished result waits in the output register
// so the next item can be taken while m_valid is still held.
// if the receiver stalls, the next result waits in the controller until the
// output register frees up.
// reset (aresetn low, synchronous) empties the table and drops m_valid; the
// table memory itself is not cleared.
module sorted_device_address_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [sdat_pkg::TYPE_W-1:0]       s_addr_type,
    input  logic [sdat_pkg::ADDR_W-1:0]       s_device_address,
    input  logic [sdat_pkg::INDEX_W-1:0]      s_entry_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic                              m_out_type,
    output logic [sdat_pkg::ADDR_W-1:0]       m_out_address,
    output logic [sdat_pkg::OUT_COUNT_W-1:0]  m_entry_count
);

    sdat_pkg::sdat_cmd_t    cmd;
    sdat_pkg::sdat_status_t status;

    sdat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sdat_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_op             (s_op),
        .in_addr_type      (s_addr_type),
        .in_device_address (s_device_address),
        .in_entry_index    (s_entry_index),
        .out_ok            (m_ok),
        .out_type          (m_out_type),
        .out_address       (m_out_address),
        .out_count         (m_entry_count)
    );

endmodule

/* verif/sorted_device_address_table_test.sv */
// testbench for the sorted device address table: directed and random ops checked against a predictor
module sorted_device_address_table_test;

    localparam logic [sdat_pkg::TYPE_W-1:0] ADDR_PUBLIC = 8'd0;
    localparam logic [sdat_pkg::TYPE_W-1:0] ADDR_RANDOM = 8'd1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic                             ok;
        logic                             out_type;
        logic [sdat_pkg::ADDR_W-1:0]      out_address;
        logic [sdat_pkg::OUT_COUNT_W-1:0] entry_count;
    } table_answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = sdat_pkg::OP_LOOKUP;
    logic [sdat_pkg::TYPE_W-1:0] s_addr_type = '0;
    logic [sdat_pkg::ADDR_W-1:0] s_device_address = '0;
    logic [sdat_pkg::INDEX_W-1:0] s_entry_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_ok;
    logic m_out_type;
    logic [sdat_pkg::ADDR_W-1:0] m_out_address;
    logic [sdat_pkg::OUT_COUNT_W-1:0] m_entry_count;

    sorted_device_address_table DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_addr_type      (s_addr_type),
        .s_device_address (s_device_address),
        .s_entry_index    (s_entry_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_out_type       (m_out_type),
        .m_out_address    (m_out_address),
        .m_entry_count    (m_entry_count)
    );

    // predicted copy of the table
    logic [sdat_pkg::KEY_W-1:0] model_records [sdat_pkg::CAPACITY];
    int model_count = 0;

    table_answer_t pending_answers [$];
    int errors = 0;
    int items_sent = 0;
    int answers_checked = 0;
    int full_rejects = 0;
    int repeat_inserts = 0;
    int unstable_rejects = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d items still awaited", cycle_count,
            pending_answers.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit address_stable(input logic [sdat_pkg::TYPE_W-1:0] atype,
                                          input logic [sdat_pkg::ADDR_W-1:0] addr);
        if (atype != ADDR_PUBLIC && atype != ADDR_RANDOM) return 1'b0;
        if (addr == '0 || addr == '1) return 1'b0;
        if (atype == ADDR_PUBLIC) return 1'b1;
        if ((addr[47:40] & sdat_pkg::RANDOM_TOP_MASK) != sdat_pkg::RANDOM_TOP_MASK)
            return 1'b0;
        return addr[45:0] != '0 && addr[45:0] != '1;
    endfunction

    function automatic table_answer_t table_apply(input logic [1:0] op,
                                                  input logic [sdat_pkg::TYPE_W-1:0] atype,
                                                  input logic [sdat_pkg::ADDR_W-1:0] addr,
                                                  input logic [sdat_pkg::INDEX_W-1:0] idx);
        table_answer_t ans;
        logic [sdat_pkg::KEY_W-1:0] key;
        int pos;
        ans = '0;
        key = {atype[0], addr};
        case (op)
            sdat_pkg::OP_LOOKUP: begin
                if (!address_stable(atype, addr)) begin
                    unstable_rejects++;
                end else begin
                    for (int i = 0; i < model_count; i++)
                        if (model_records[i] == key) ans.ok = 1'b1;
                end
            end
            sdat_pkg::OP_INSERT: begin
                if (!address_stable(atype, addr)) begin
                    unstable_rejects++;
                end else begin
                    // first slot holding a key not below the new one
                    pos = 0;
                    while (pos < model_count && model_records[pos] < key) pos++;
                    if (pos < model_count && model_records[pos] == key) begin
                        ans.ok = 1'b1;
                        repeat_inserts++;
                    end else if (model_count >= sdat_pkg::CAPACITY) begin
                        full_rejects++;
                    end else begin
                        for (int i = model_count; i > pos; i--)
                            model_records[i] = model_records[i-1];
                        model_records[pos] = key;
                        model_count++;
                        ans.ok = 1'b1;
                    end
                end
            end
            sdat_pkg::OP_CLEAR: begin
                model_count = 0;
                ans.ok = 1'b1;
            end
            sdat_pkg::OP_GET: begin
                if (int'(idx) < model_count) begin
                    ans.ok = 1'b1;
                    ans.out_type = model_records[idx][sdat_pkg::ADDR_W];
                    ans.out_address = model_records[idx][sdat_pkg::ADDR_W-1:0];
                end
            end
        endcase
        ans.entry_count = sdat_pkg::OUT_COUNT_W'(model_count);
        return ans;
    endfunction

    task automatic send_item(input logic [1:0] op,
                             input logic [sdat_pkg::TYPE_W-1:0] atype,
                             input logic [sdat_pkg::ADDR_W-1:0] addr,
                             input logic [sdat_pkg::INDEX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_addr_type <= atype;
        s_device_address <= addr;
        s_entry_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_answers.push_back(table_apply(op, atype, addr, idx));
        items_sent++;
    endtask

    task automatic check_answer();
        table_answer_t exp;
        if (pending_answers.size() == 0) begin
            $error("result item with nothing expected: ok %0b count %0d", m_ok, m_entry_count);
            errors++;
        end else begin
            exp = pending_answers.pop_front();
            answers_checked++;
            if (m_ok !== exp.ok) begin
                $error("ok: expected %0b, got %0b", exp.ok, m_ok);
                errors++;
            end
            if (m_out_type !== exp.out_type) begin
                $error("out_type: expected %0b, got %0b", exp.out_type, m_out_type);
                errors++;
            end
            if (m_out_address !== exp.out_address) begin
                $error("out_address: expected %h, got %h", exp.out_address, m_out_address);
                errors++;
            end
            if (m_entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count, m_entry_count);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) check_answer();
    end

    function automatic logic [sdat_pkg::ADDR_W-1:0] random_address();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[sdat_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [sdat_pkg::KEY_W-1:0] random_stable_record();
        logic [sdat_pkg::TYPE_W-1:0] atype;
        logic [sdat_pkg::ADDR_W-1:0] addr;
        atype = $urandom_range(1) ? ADDR_RANDOM : ADDR_PUBLIC;
        if ($urandom_range(9) == 0) begin
            // keys at the ends of each type's range
            if (atype == ADDR_PUBLIC)
                addr = $urandom_range(1) ? 48'h0000_0000_0001 : 48'hffff_ffff_fffe;
            else
                addr = $urandom_range(1) ? 48'hc000_0000_0001 : 48'hffff_ffff_fffe;
        end else begin
            do begin
                addr = random_address();
                if (atype == ADDR_RANDOM) addr[47:46] = 2'b11;
            end while (!address_stable(atype, addr));
        end
        return {atype[0], addr};
    endfunction

    task automatic send_unstable(input logic [1:0] op);
        logic [sdat_pkg::ADDR_W-1:0] addr;
        logic [sdat_pkg::TYPE_W-1:0] atype;
        case ($urandom_range(4))
            0: begin
                atype = sdat_pkg::TYPE_W'($urandom_range(255, 2));
                addr = random_address();
            end
            1: begin
                atype = $urandom_range(1) ? ADDR_RANDOM : ADDR_PUBLIC;
                addr = '0;
            end
            2: begin
                atype = $urandom_range(1) ? ADDR_RANDOM : ADDR_PUBLIC;
                addr = '1;
            end
            3: begin
                atype = ADDR_RANDOM;
                addr = random_address();
                addr[47:46] = 2'($urandom_range(2));
            end
            default: begin
                atype = ADDR_RANDOM;
                addr = {2'b11, 46'h0};
            end
        endcase
        send_item(op, atype, addr, sdat_pkg::INDEX_W'($urandom_range(255)));
    endtask

    task automatic test_empty_table();
        send_item(sdat_pkg::OP_GET, ADDR_PUBLIC, 48'h0000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_GET, 8'hff, 48'hffff_ffff_ffff, 8'd255);
        send_item(sdat_pkg::OP_LOOKUP, ADDR_PUBLIC, 48'h1234_5678_9abc, 8'd0);
        send_item(sdat_pkg::OP_CLEAR, 8'hff, 48'hffff_ffff_ffff, 8'd255);
    endtask

    task automatic test_unstable_addresses();
        send_item(sdat_pkg::OP_INSERT, 8'd2, 48'h1234_5678_9abc, 8'd0);
        send_item(sdat_pkg::OP_INSERT, 8'hff, 48'hc123_4567_89ab, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_PUBLIC, 48'h0000_0000_0000, 8'd0);
        send_item(sdat_pkg::OP_LOOKUP, ADDR_PUBLIC, 48'hffff_ffff_ffff, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_RANDOM, 48'h8000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_RANDOM, 48'hc000_0000_0000, 8'd0);
        send_item(sdat_pkg::OP_LOOKUP, ADDR_RANDOM, 48'h3fff_ffff_ffff, 8'd0);
    endtask

    task automatic test_sorted_insert();
        // mostly descending keys so inserts shift the earlier ones up; the last repeats a key
        send_item(sdat_pkg::OP_INSERT, ADDR_RANDOM, 48'hffff_ffff_fffe, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_RANDOM, 48'hc000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_PUBLIC, 48'hffff_ffff_fffe, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_PUBLIC, 48'h0000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_PUBLIC, 48'h8000_0000_0000, 8'd0);
        send_item(sdat_pkg::OP_INSERT, ADDR_PUBLIC, 48'h0000_0000_0001, 8'd0);
    endtask

    task automatic test_lookup_and_get();
        send_item(sdat_pkg::OP_LOOKUP, ADDR_PUBLIC, 48'h0000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_LOOKUP, ADDR_RANDOM, 48'h0000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_LOOKUP, ADDR_RANDOM, 48'hc000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_LOOKUP, ADDR_PUBLIC, 48'hc000_0000_0001, 8'd0);
        send_item(sdat_pkg::OP_GET, 8'hff, 48'hffff_ffff_ffff, 8'd0);
        send_item(sdat_pkg::OP_GET, ADDR_PUBLIC, 48'h0, 8'd4);
        send_item(sdat_pkg::OP_GET, ADDR_PUBLIC, 48'h0, 8'd5);
        send_item(sdat_pkg::OP_GET, ADDR_PUBLIC, 48'h0, 8'd255);
    endtask

    task automatic test_clear();
        send_item(sdat_pkg::OP_CLEAR, ADDR_PUBLIC, 48'h0, 8'd0);
        send_item(sdat_pkg::OP_GET, ADDR_PUBLIC, 48'h0, 8'd0);
        send_item(sdat_pkg::OP_LOOKUP, ADDR_PUBLIC, 48'h0000_0000_0001, 8'd0);
    endtask

    // runs of ops on a freshly cleared table, long enough to fill it at times
    task automatic test_random_sequences(input int n_items);
        logic [sdat_pkg::KEY_W-1:0] used [$];
        logic [sdat_pkg::KEY_W-1:0] rec;
        int sent;
        int run_len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            send_item(sdat_pkg::OP_CLEAR, sdat_pkg::TYPE_W'($urandom_range(255)),
                random_address(), sdat_pkg::INDEX_W'($urandom_range(255)));
            sent++;
            used.delete();
            run_len = $urandom_range(50, 8);
            repeat (run_len) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    if (used.size() != 0 && $urandom_range(99) < 25) begin
                        rec = used[$urandom_range(used.size() - 1)];
                    end else begin
                        rec = random_stable_record();
                        used.push_back(rec);
                    end
                    send_item(sdat_pkg::OP_INSERT, {7'd0, rec[sdat_pkg::ADDR_W]},
                        rec[sdat_pkg::ADDR_W-1:0],
                        sdat_pkg::INDEX_W'($urandom_range(255)));
                end else if (pick < 65) begin
                    if (used.size() != 0 && $urandom_range(99) < 60)
                        rec = used[$urandom_range(used.size() - 1)];
                    else
                        rec = random_stable_record();
                    // flipping the type misses an otherwise present address
                    if ($urandom_range(9) == 0) rec[sdat_pkg::ADDR_W] = ~rec[sdat_pkg::ADDR_W];
                    send_item(sdat_pkg::OP_LOOKUP, {7'd0, rec[sdat_pkg::ADDR_W]},
                        rec[sdat_pkg::ADDR_W-1:0],
                        sdat_pkg::INDEX_W'($urandom_range(255)));
                end else if (pick < 87) begin
                    send_item(sdat_pkg::OP_GET, sdat_pkg::TYPE_W'($urandom_range(255)),
                        random_address(),
                        ($urandom_range(9) == 0)
                            ? sdat_pkg::INDEX_W'($urandom_range(255))
                            : sdat_pkg::INDEX_W'($urandom_range(model_count + 1)));
                end else if (pick < 95) begin
                    send_unstable($urandom_range(1) ? sdat_pkg::OP_INSERT
                                                    : sdat_pkg::OP_LOOKUP);
                end else begin
                    send_item(2'($urandom_range(3)), sdat_pkg::TYPE_W'($urandom_range(255)),
                        random_address(), sdat_pkg::INDEX_W'($urandom_range(255)));
                end
                sent++;
            end
        end
    endtask

    initial begin
        send_idle_pct = 15;
        recv_idle_pct = 86;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_unstable_addresses();
        test_sorted_insert();
        test_lookup_and_get();
        test_clear();
        test_random_sequences(550);
        send_idle_pct = 86;
        recv_idle_pct = 15;
        test_random_sequences(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sequences(550);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d items sent, %0d results checked over three idling mixes",
            items_sent, answers_checked);
        $display("%0d inserts into a full table, %0d repeated inserts, %0d unstable addresses",
            full_rejects, repeat_inserts, unstable_rejects);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
